[src/xphc_pkg.sv]
// xphc_pkg: shared types and constants for the xor prefix hash compare block
// no dependencies

package xphc_pkg;

	localparam int KIND_W     = 2;
	localparam int FIELD_W    = 10;
	localparam int WORD_W     = 32;
	localparam int MAX_HASH_W = 64;
	localparam int EXT_W      = 17;

	localparam int DEF_SEQ_DEPTH    = 1024;
	localparam int DEF_SYMBOL_COUNT = 1024;
	localparam int DEF_HASH_WIDTH   = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD     = 2'd0,
		KIND_APPEND_S = 2'd1,
		KIND_APPEND_T = 2'd2,
		KIND_QUERY    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_APPEND = 4'b0010,
		ST_QLO    = 4'b0100,
		ST_QCMP   = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_lo;
		logic wr_pre;
		logic emit;
		logic answer;
	} cmd_t;

endpackage

[src/xphc_ctrl.sv]
// xphc_ctrl: request sequencer for the xor prefix hash compare block
// depends on xphc_pkg

module xphc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [xphc_pkg::KIND_W-1:0] kind,
	output logic                        busy,
	output xphc_pkg::cmd_t              cmd
);
	import xphc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		busy        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
				if (start) begin
					case (kind_t'(kind))
						KIND_LOAD: begin
							cmd.emit = 1'b1;
						end
						KIND_APPEND_S, KIND_APPEND_T: begin
							state_d = ST_APPEND;
						end
						KIND_QUERY: begin
							state_d = ST_QLO;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_APPEND: begin
				cmd.wr_pre = 1'b1;
				cmd.emit   = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_QLO: begin
				cmd.rd_lo = 1'b1;
				state_d   = ST_QCMP;
			end
			ST_QCMP: begin
				cmd.emit   = 1'b1;
				cmd.answer = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/xphc_datapath.sv]
// xphc_datapath: hash table, prefix stores, running xor and result registers
// depends on xphc_pkg; driven by xphc_ctrl

module xphc_datapath #(
	parameter int SEQ_DEPTH    = xphc_pkg::DEF_SEQ_DEPTH,
	parameter int SYMBOL_COUNT = xphc_pkg::DEF_SYMBOL_COUNT,
	parameter int HASH_WIDTH   = xphc_pkg::DEF_HASH_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  xphc_pkg::cmd_t               cmd,
	input  logic [xphc_pkg::KIND_W-1:0]  kind,
	input  logic [xphc_pkg::FIELD_W-1:0] position,
	input  logic [xphc_pkg::FIELD_W-1:0] symbol,
	input  logic [xphc_pkg::WORD_W-1:0]  hash_word,
	input  logic [xphc_pkg::FIELD_W-1:0] start_s,
	input  logic [xphc_pkg::FIELD_W-1:0] start_t,
	input  logic [xphc_pkg::FIELD_W-1:0] span,
	output logic                         done,
	output logic                         is_answer,
	output logic                         match,
	output logic                         range_error
);
	import xphc_pkg::*;

	localparam int SA_W  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int SY_W  = $clog2(SYMBOL_COUNT);
	localparam int LEN_W = $clog2(SEQ_DEPTH + 1);
	localparam logic [EXT_W-1:0] SEQ_LIM = EXT_W'(SEQ_DEPTH);
	localparam logic [EXT_W-1:0] SYM_LIM = EXT_W'(SYMBOL_COUNT);

	logic [HASH_WIDTH-1:0] tbl_mem [SYMBOL_COUNT];
	logic [HASH_WIDTH-1:0] store_s [SEQ_DEPTH];
	logic [HASH_WIDTH-1:0] store_t [SEQ_DEPTH];

	logic [EXT_W-1:0] pos_ext, sym_ext, end_s, end_t, lo_s, lo_t, len_plus;
	logic [MAX_HASH_W-1:0] word_ext;
	logic sym_ok, pos_ok, err;

	logic [HASH_WIDTH-1:0] tbl_rd_q, s_rd_q, t_rd_q, hi_s_q, hi_t_q;
	logic [HASH_WIDTH-1:0] run_s_q, run_t_q, run_cur, word_sel, run_new, hs, ht;
	logic [LEN_W-1:0] len_s_q, len_t_q, len_next_q;
	logic [SA_W-1:0] pos_addr_q, lo_s_addr_q, lo_t_addr_q, s_rd_addr, t_rd_addr;
	logic seq_t_q, pos_zero_q, pos_ok_q, sym_ok_q, lo_zero_s_q, lo_zero_t_q, err_q;
	logic wr_s, wr_t;
	logic done_q, is_answer_q, match_q, range_error_q;

	assign pos_ext  = EXT_W'(position);
	assign sym_ext  = EXT_W'(symbol);
	assign end_s    = EXT_W'(start_s) + EXT_W'(span);
	assign end_t    = EXT_W'(start_t) + EXT_W'(span);
	assign lo_s     = EXT_W'(start_s) - EXT_W'(1);
	assign lo_t     = EXT_W'(start_t) - EXT_W'(1);
	assign len_plus = pos_ext + EXT_W'(1);
	assign word_ext = MAX_HASH_W'(hash_word);
	assign sym_ok   = sym_ext < SYM_LIM;
	assign pos_ok   = pos_ext < SEQ_LIM;
	assign err      = (end_s >= EXT_W'(len_s_q)) || (end_t >= EXT_W'(len_t_q));

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_t_q     <= (kind == KIND_APPEND_T);
			pos_addr_q  <= pos_ext[SA_W-1:0];
			pos_zero_q  <= (position == '0);
			pos_ok_q    <= pos_ok;
			sym_ok_q    <= sym_ok;
			len_next_q  <= len_plus[LEN_W-1:0];
			lo_s_addr_q <= lo_s[SA_W-1:0];
			lo_t_addr_q <= lo_t[SA_W-1:0];
			lo_zero_s_q <= (start_s == '0);
			lo_zero_t_q <= (start_t == '0);
			err_q       <= err;
		end
		if (cmd.rd_lo) begin
			hi_s_q <= s_rd_q;
			hi_t_q <= t_rd_q;
		end
	end

	// hash table
	always_ff @(posedge clk) begin
		if (cmd.capture && kind == KIND_LOAD && sym_ok) begin
			tbl_mem[sym_ext[SY_W-1:0]] <= word_ext[HASH_WIDTH-1:0];
		end
		tbl_rd_q <= tbl_mem[sym_ext[SY_W-1:0]];
	end

	// append
	assign word_sel = sym_ok_q ? tbl_rd_q : '0;
	assign run_cur  = seq_t_q ? run_t_q : run_s_q;
	assign run_new  = pos_zero_q ? word_sel : (run_cur ^ word_sel);
	assign wr_s     = cmd.wr_pre && pos_ok_q && !seq_t_q;
	assign wr_t     = cmd.wr_pre && pos_ok_q && seq_t_q;

	// prefix stores, end words read at capture, start words in the following cycle
	assign s_rd_addr = cmd.rd_lo ? lo_s_addr_q : end_s[SA_W-1:0];
	assign t_rd_addr = cmd.rd_lo ? lo_t_addr_q : end_t[SA_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_s) begin
			store_s[pos_addr_q] <= run_new;
		end
		s_rd_q <= store_s[s_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_t) begin
			store_t[pos_addr_q] <= run_new;
		end
		t_rd_q <= store_t[t_rd_addr];
	end

	assign hs = hi_s_q ^ (lo_zero_s_q ? '0 : s_rd_q);
	assign ht = hi_t_q ^ (lo_zero_t_q ? '0 : t_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s_q       <= '0;
			run_t_q       <= '0;
			len_s_q       <= '0;
			len_t_q       <= '0;
			done_q        <= 1'b0;
			is_answer_q   <= 1'b0;
			match_q       <= 1'b0;
			range_error_q <= 1'b0;
		end else begin
			if (wr_s) begin
				run_s_q <= run_new;
				len_s_q <= len_next_q;
			end
			if (wr_t) begin
				run_t_q <= run_new;
				len_t_q <= len_next_q;
			end
			done_q        <= cmd.emit;
			is_answer_q   <= cmd.answer;
			match_q       <= cmd.answer && !err_q && (hs == ht);
			range_error_q <= cmd.answer && err_q;
		end
	end

	assign done        = done_q;
	assign is_answer   = is_answer_q;
	assign match       = match_q;
	assign range_error = range_error_q;

endmodule

[src/xor_prefix_subarray_hash_compare.sv]
// xor_prefix_subarray_hash_compare: top level, sequencer plus datapath
// depends on xphc_pkg, xphc_ctrl, xphc_datapath
// done follows accept (load), ST_APPEND (append), ST_QLO then ST_QCMP (query);
// loads may come back to back, appends and queries hold busy; a query reads end
// then start words in turn on the single read port of each prefix store
// arst_n clears the sequencer, running xors, loaded lengths, the strobe and flags

module xor_prefix_subarray_hash_compare #(
	parameter int SEQ_DEPTH    = xphc_pkg::DEF_SEQ_DEPTH,
	parameter int SYMBOL_COUNT = xphc_pkg::DEF_SYMBOL_COUNT,
	parameter int HASH_WIDTH   = xphc_pkg::DEF_HASH_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [xphc_pkg::KIND_W-1:0]  kind,
	input  logic [xphc_pkg::FIELD_W-1:0] position,
	input  logic [xphc_pkg::FIELD_W-1:0] symbol,
	input  logic [xphc_pkg::WORD_W-1:0]  hash_word,
	input  logic [xphc_pkg::FIELD_W-1:0] start_s,
	input  logic [xphc_pkg::FIELD_W-1:0] start_t,
	input  logic [xphc_pkg::FIELD_W-1:0] span,
	output logic                         done,
	output logic                         is_answer,
	output logic                         match,
	output logic                         range_error
);
	import xphc_pkg::*;

	cmd_t cmd;

	xphc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.cmd    (cmd)
	);

	xphc_datapath #(
		.SEQ_DEPTH    (SEQ_DEPTH),
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.HASH_WIDTH   (HASH_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.position    (position),
		.symbol      (symbol),
		.hash_word   (hash_word),
		.start_s     (start_s),
		.start_t     (start_t),
		.span        (span),
		.done        (done),
		.is_answer   (is_answer),
		.match       (match),
		.range_error (range_error)
	);

endmodule

[src/xphc_checker.sv]
// xphc_checker: port level checks on request timing and result flags
// depends on xphc_pkg; bound to xor_prefix_subarray_hash_compare

module xphc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [xphc_pkg::KIND_W-1:0] kind,
	input logic                        done,
	input logic                        is_answer,
	input logic                        match,
	input logic                        range_error
);
	import xphc_pkg::*;

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_LOAD |=> done && !is_answer && !busy)
		else $error("load request did not give a plain result");

	a_append_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == KIND_APPEND_S || kind == KIND_APPEND_T)
		|-> ##2 (done && !is_answer && !busy))
		else $error("append request result missing");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_QUERY |-> ##3 (done && is_answer && !busy))
		else $error("query request answer missing");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(match && range_error) && (is_answer || (!match && !range_error)))
		else $error("inconsistent result flags");

endmodule

bind xor_prefix_subarray_hash_compare xphc_checker u_chk (.*);
